[sv/assert_macros.svh]
// assertion macros shared by the turtle rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

[sv/lst3d_pkg.sv]
// types and constants for the 3d turtle core
// no dependencies
`timescale 1ns / 1ps
package lst3d_pkg;
  // fraction bits of the q2.14 frame and q18.14 positions
  localparam int FRAC_BITS = 14;

  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_CARET = 8'h5E;
  localparam logic [7:0] SYM_AMP   = 8'h26;
  localparam logic [7:0] SYM_SLASH = 8'h2F;
  localparam logic [7:0] SYM_BSL   = 8'h5C;
  localparam logic [7:0] SYM_BAR   = 8'h7C;
  localparam logic [7:0] SYM_PUSH  = 8'h28;
  localparam logic [7:0] SYM_POP   = 8'h29;

  localparam logic [1:0] ST_SEG   = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  localparam logic CFG_COS = 1'b0;
  localparam logic CFG_SIN = 1'b1;

  typedef logic signed [15:0] vcomp_t;
  typedef logic signed [31:0] pcomp_t;

  typedef struct packed {
    pcomp_t [2:0] pos;
    vcomp_t [2:0] h;
    vcomp_t [2:0] l;
    vcomp_t [2:0] u;
  } frame_t;

  typedef struct packed {
    logic [1:0] status;
    pcomp_t [2:0] st;
    pcomp_t [2:0] en;
  } result_t;

  function automatic vcomp_t sat16n(input vcomp_t v);
    sat16n = (v == 16'sh8000) ? 16'sh7FFF : -v;
  endfunction
endpackage

[sv/lst3d_rot.sv]
// one pair rotation for a single vector component, rounded and saturated
// depends on lst3d_pkg
`timescale 1ns / 1ps
module lst3d_rot import lst3d_pkg::*; (
  input  vcomp_t a,
  input  vcomp_t b,
  input  vcomp_t c,
  input  vcomp_t s,
  input  logic   neg,
  output vcomp_t na,
  output vcomp_t nb
);
  logic signed [33:0] as_p, bs_p, ac_p, bc_p, sa, sb;

  function automatic vcomp_t rnd(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = (v + (34'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (t > 34'sd32767) rnd = 16'sh7FFF;
    else if (t < -34'sd32768) rnd = 16'sh8000;
    else rnd = t[15:0];
  endfunction

  always_comb begin
    ac_p = 34'(a) * 34'(c);
    bc_p = 34'(b) * 34'(c);
    as_p = 34'(a) * 34'(s);
    bs_p = 34'(b) * 34'(s);
    sa = neg ? -as_p : as_p;
    sb = neg ? -bs_p : bs_p;
    na = rnd(ac_p + sb);
    nb = rnd(bc_p - sa);
  end
endmodule

[sv/lsystem_turtle_3d_core.sv]
// 3d turtle interpreter for l-system symbol streams, top level
// depends on lst3d_pkg, lst3d_rot and assert_macros.svh
//
// channel | dir | content
// in_     | in  | tdata = symbol[7:0]; tuser = draw_flag
// out_    | out | tdata = status, start xyz, end xyz; 2+192 bits padded to 200
// cfg_    | in  | index 0 cos_angle, 1 sin_angle
//
// one symbol per cycle while in_tready is high; the frame registers update in
// the accepting cycle and a result shows on out_ the cycle after, or later
// via the spare if out_ is held; a pop that finds an entry stalls the input:
// in_tready drops for the cycle in which the stack read returns
// reset restores the unit frame and an empty stack; stack contents undefined
// out_ has one output register and one spare; the input stalls while the
// spare is full and while a pop's stack read returns
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lsystem_turtle_3d_core import lst3d_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // symbol[7:0]
  input  logic         in_tuser,   // draw_flag
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [199:0] out_tdata,  // status, start_x/y/z, end_x/y/z, zero pad
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  vcomp_t cos_r, sin_r;
  frame_t fr_r, fr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic pop_r;
  logic ov_r;
  result_t res_r;
  logic sk_full_r;
  result_t sk_r;

  // stack memory
  frame_t mem [STACK_DEPTH];
  frame_t rd_q;
  logic [AW-1:0] rd_a;
  logic wr_en;

  // output register plus one spare, input stalls when the spare is full or a pop reads the stack
  logic acc, emit;
  result_t emit_d;
  assign in_tready = !pop_r && !sk_full_r;
  assign acc = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  logic [7:0] sym;
  assign sym = in_tdata;

  // rotation selection
  vcomp_t [2:0] ra, rb, na, nb;
  logic neg;
  genvar g;
  for (g = 0; g < 3; g++) begin : g_rot
    lst3d_rot u_rot (
      .a(ra[g]), .b(rb[g]), .c(cos_r), .s(sin_r), .neg(neg),
      .na(na[g]), .nb(nb[g]));
  end

  always_comb begin
    neg = (sym == SYM_MINUS) || (sym == SYM_AMP) || (sym == SYM_BSL);
    if (sym == SYM_SLASH || sym == SYM_BSL) begin
      ra = fr_r.l; rb = fr_r.u;
    end else if (sym == SYM_CARET || sym == SYM_AMP) begin
      ra = fr_r.h; rb = fr_r.u;
    end else begin
      ra = fr_r.h; rb = fr_r.l;
    end
  end

  always_comb begin
    logic signed [32:0] t;
    t = '0;
    fr_nxt = fr_r;
    cnt_nxt = cnt_r;
    emit = 1'b0;
    emit_d = '0;
    wr_en = 1'b0;
    rd_a = AW'(cnt_r - CW'(1));
    if (pop_r) begin
      fr_nxt = rd_q;
    end else if (acc) begin
      unique case (sym)
        SYM_PLUS, SYM_MINUS: begin fr_nxt.h = na; fr_nxt.l = nb; end
        SYM_CARET, SYM_AMP: begin fr_nxt.h = na; fr_nxt.u = nb; end
        SYM_SLASH, SYM_BSL: begin fr_nxt.l = na; fr_nxt.u = nb; end
        SYM_BAR: begin
          for (int i = 0; i < 3; i++) begin
            fr_nxt.h[i] = sat16n(fr_r.h[i]);
            fr_nxt.l[i] = sat16n(fr_r.l[i]);
          end
        end
        SYM_PUSH: begin
          if (cnt_r >= CW'(STACK_DEPTH)) begin
            emit = 1'b1; emit_d.status = ST_OVER;
          end else begin
            wr_en = 1'b1; cnt_nxt = cnt_r + CW'(1);
          end
        end
        SYM_POP: begin
          if (cnt_r == '0) begin
            emit = 1'b1; emit_d.status = ST_UNDER;
          end else begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end
        default: begin
          for (int i = 0; i < 3; i++) begin
            t = 33'(fr_r.pos[i]) + 33'(fr_r.h[i]);
            if (t > 33'sh0_7FFF_FFFF) fr_nxt.pos[i] = 32'sh7FFF_FFFF;
            else if (t < -33'sh0_8000_0000) fr_nxt.pos[i] = 32'sh8000_0000;
            else fr_nxt.pos[i] = t[31:0];
          end
          emit = in_tuser;
          emit_d.status = ST_SEG;
          emit_d.st = fr_r.pos;
          emit_d.en = fr_nxt.pos;
        end
      endcase
    end
  end

  logic start_pop;
  assign start_pop = acc && sym == SYM_POP && cnt_r != '0;

  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(cnt_r)] <= fr_r;
    rd_q <= mem[rd_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r <= 16'sd16384;
      sin_r <= '0;
      fr_r.pos <= '0;
      fr_r.h <= {16'sd0, 16'sd0, 16'sd16384};
      fr_r.l <= {16'sd0, 16'sd16384, 16'sd0};
      fr_r.u <= {16'sd16384, 16'sd0, 16'sd0};
      cnt_r <= '0;
      pop_r <= 1'b0;
      ov_r <= 1'b0;
      sk_full_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_COS) cos_r <= cfg_data;
        else sin_r <= cfg_data;
      end
      fr_r <= fr_nxt;
      cnt_r <= cnt_nxt;
      pop_r <= start_pop;
      // spare full: output register stays full, spare drains into it
      if (sk_full_r) begin
        if (out_tready) sk_full_r <= 1'b0;
      end else if (emit) begin
        if (ov_r && !out_tready) sk_full_r <= 1'b1;
        else ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sk_full_r) begin
      if (out_tready) res_r <= sk_r;
    end else if (emit) begin
      if (ov_r && !out_tready) sk_r <= emit_d;
      else res_r <= emit_d;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {6'd0, res_r.en[2], res_r.en[1], res_r.en[0],
                      res_r.st[2], res_r.st[1], res_r.st[0], res_r.status};

  `ASSERT_NEXT(a_pop_stall, start_pop, !in_tready)
  `ASSERT_IMPLIES(a_cnt_range, 1'b1, cnt_r <= CW'(STACK_DEPTH))
  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `ASSERT_IMPLIES(a_spare_behind, sk_full_r, ov_r)
endmodule
